/* rtl/core/kla_pkg.sv */
// kla_pkg: shared types and codes for the k-mer level accumulator.
// No dependencies; imported by kmer_level_accumulate_top.
package kla_pkg;

  localparam int VALUE_BITS = 32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic REG_MIN_LEVEL = 1'b0;
  localparam logic REG_MAX_LEVEL = 1'b1;

  // (4^k - 1) / 3 is the pattern 0101..01 holding k pairs
  localparam logic [31:0] LEVEL_PAT = 32'h5555_5555;

  typedef enum logic [1:0] {
    S_IDLE,
    S_QUERY,
    S_DRAIN,
    S_RESULT
  } state_t;

endpackage

/* rtl/core/kmer_level_accumulate_top.sv */
// Flow: a write goes from acceptance to S_RESULT and then into the output register;
// a query over n levels does one table read per level in S_QUERY, then S_DRAIN, S_RESULT.
// Throughput: one item at a time; the single table read port serves one query, and
// the next item is taken once the result is registered, which waits while m_tready is low.
// Reset (rst, synchronous): control clears, min_level = 0, max_level = 5; the
// weight table is not cleared and holds no valid data until written.
module kmer_level_accumulate_top
  import kla_pkg::*;
#(
  parameter int MAX_LEVEL = 5,
  parameter int STRIDE    = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // level[2:0], kmer[12:3], column[14:13], value[46:15], pad
  input  logic [0:0]  s_tuser,   // command[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // sum[31:0]
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [2:0]  cfg_data
);

  localparam int DEPTH = STRIDE * (((1 << (2 * (MAX_LEVEL + 1))) - 1) / 3);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [31:0] STRIDE_W = 32'(STRIDE);

  function automatic logic [AW-1:0] addr_of(input logic [2:0] k, input logic [9:0] row,
                                            input logic [1:0] col);
    logic [31:0] mask;
    logic [31:0] base;
    logic [31:0] offs;
    mask = (32'd1 << {k, 1'b0}) - 32'd1;
    base = (LEVEL_PAT & mask) * STRIDE_W;
    offs = (({22'd0, row} & mask) * STRIDE_W) + {30'd0, col};
    return AW'(base + offs);
  endfunction

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data;

  state_t state, state_next;

  logic [2:0]  min_level, max_level;
  logic [9:0]  q_kmer;
  logic [1:0]  q_col;
  logic [2:0]  lvl_k;
  logic signed [VALUE_BITS-1:0] acc;
  logic        sat;
  logic        rd_valid;
  logic [1:0]  pend_status;

  logic [2:0]  in_level;
  logic [9:0]  in_kmer;
  logic [1:0]  in_col;
  logic [31:0] in_value;
  logic        in_cmd;
  logic        accept, wr_ok, q_ok, q_empty, mem_we, rd_en, out_load, go_query;
  logic [AW-1:0] wr_addr, rd_addr;
  logic signed [VALUE_BITS:0] acc_sum;

  assign in_level = s_tdata[2:0];
  assign in_kmer  = s_tdata[12:3];
  assign in_col   = s_tdata[14:13];
  assign in_value = s_tdata[46:15];
  assign in_cmd   = s_tuser[0];

  assign accept = s_tvalid && s_tready;

  assign wr_ok = ({1'b0, in_level} <= 4'(MAX_LEVEL)) &&
                 ((in_kmer >> {in_level, 1'b0}) == 10'd0) &&
                 ({3'd0, in_col} < 5'(STRIDE));
  assign q_ok  = ({1'b0, max_level} <= 4'(MAX_LEVEL)) &&
                 ({1'b0, min_level} <= 4'(MAX_LEVEL)) &&
                 ((in_kmer >> {max_level, 1'b0}) == 10'd0) &&
                 ({3'd0, in_col} < 5'(STRIDE));
  assign q_empty  = min_level > max_level;
  assign go_query = (in_cmd == CMD_QUERY) && q_ok && !q_empty;

  assign mem_we  = accept && (in_cmd == CMD_WRITE) && wr_ok;
  assign wr_addr = addr_of(in_level, in_kmer, in_col);
  assign rd_en   = (state == S_QUERY);
  assign rd_addr = addr_of(lvl_k, q_kmer, q_col);

  assign acc_sum = {acc[VALUE_BITS-1], acc} + {rd_data[VALUE_BITS-1], rd_data};

  // Reads and writes never overlap: one item is in flight at a time.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = go_query ? S_QUERY : S_RESULT;
        end
      end
      S_QUERY: begin
        if (lvl_k == max_level) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        out_load = !m_tvalid || m_tready;
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level <= 3'd0;
      max_level <= 3'd5;
    end else if (cfg_we) begin
      unique case (cfg_index[0])
        REG_MIN_LEVEL: min_level <= cfg_data;
        REG_MAX_LEVEL: max_level <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_kmer      <= in_kmer;
      q_col       <= in_col;
      lvl_k       <= min_level;
      acc         <= '0;
      sat         <= 1'b0;
      pend_status <= (in_cmd == CMD_WRITE) ? (wr_ok ? ST_OK : ST_RANGE)
                                           : (q_ok ? ST_OK : ST_RANGE);
    end else begin
      if (rd_en && (lvl_k != max_level)) begin
        lvl_k <= lvl_k + 3'd1;
      end
      if (rd_valid) begin
        if (acc_sum[VALUE_BITS] != acc_sum[VALUE_BITS-1]) begin
          acc <= acc_sum[VALUE_BITS] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                     : {1'b0, {(VALUE_BITS-1){1'b1}}};
          sat <= 1'b1;
        end else begin
          acc <= acc_sum[VALUE_BITS-1:0];
        end
      end
    end
    if (out_load) begin
      m_tdata <= acc;
      m_tuser <= sat ? ST_SAT : pend_status;
    end
  end

`ifndef SYNTH
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_RANGE)) |-> (m_tdata == 32'd0))
    else $error("range error result carries a non-zero sum");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == ST_OK) || (m_tuser == ST_RANGE) || (m_tuser == ST_SAT)))
    else $error("undefined status code");

  a_rd_window: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> ((state == S_QUERY) || (state == S_DRAIN)))
    else $error("table read data arrived outside a query");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT) && !out_load |=> (state == S_RESULT))
    else $error("result dropped while output stalled");
`endif

endmodule
